[sv/evad_pkg.sv]
// ----------------------------------------------------------------------------
// evad_pkg
// Shared widths, register indexes, reset values and result field positions
// of the energy voice activity detector.
// ----------------------------------------------------------------------------
package evad_pkg;

    // Default maximum frame length in samples
    localparam int unsigned FRAME_MAX_DEF = 4096;

    // Input and result field widths
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned SQ_W       = 31;   // 32768^2 = 2^30 needs 31 bits
    localparam int unsigned SUM_W      = 43;
    localparam int unsigned QUIET_W    = 16;
    localparam int unsigned SEG_W      = 32;
    localparam int unsigned TIME_W     = 48;

    // Configuration register widths
    localparam int unsigned FLEN_W     = 13;
    localparam int unsigned NEED_W     = 16;
    localparam int unsigned THR_W      = 31;
    localparam int unsigned MILLIS_W   = 16;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SILENCE_NEEDED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEECH_THR     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SILENCE_THR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_MILLIS   = 3'd4;

    localparam logic [FLEN_W-1:0]   RST_FRAME_LENGTH   = 13'd320;
    localparam logic [NEED_W-1:0]   RST_SILENCE_NEEDED = 16'd25;
    localparam logic [THR_W-1:0]    RST_SPEECH_THR     = 31'd687;
    localparam logic [THR_W-1:0]    RST_SILENCE_THR    = 31'd268;
    localparam logic [MILLIS_W-1:0] RST_FRAME_MILLIS   = 16'd20;

    // Stream widths, padded to whole bytes
    localparam int unsigned S_TDATA_W  = 24;
    localparam int unsigned M_TDATA_W  = 88;

    // Result field positions in m_tdata
    localparam int unsigned M_STARTED_BIT = 0;
    localparam int unsigned M_ENDED_BIT   = 1;
    localparam int unsigned M_INSPEECH_BIT = 2;
    localparam int unsigned M_SEG_LSB     = 3;
    localparam int unsigned M_TIME_LSB    = M_SEG_LSB + SEG_W;
    localparam int unsigned M_USED_W      = M_TIME_LSB + TIME_W;

endpackage

[sv/evad_cfg_regs.sv]
// ----------------------------------------------------------------------------
// evad_cfg_regs
// Configuration register bank with the effective frame length and the
// registered threshold levels scaled by that length.
// ----------------------------------------------------------------------------
module evad_cfg_regs #(
    parameter int unsigned FRAME_MAX = evad_pkg::FRAME_MAX_DEF,
    parameter int unsigned LEN_W     = $clog2(FRAME_MAX + 1),
    parameter int unsigned LVL_W     = evad_pkg::THR_W + LEN_W
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [evad_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [evad_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic [LEN_W-1:0]                  eff_len,
    output logic [LVL_W-1:0]                  start_level,
    output logic [LVL_W-1:0]                  quiet_level,
    output logic [evad_pkg::NEED_W-1:0]       silence_needed,
    output logic [evad_pkg::MILLIS_W-1:0]     frame_millis
);
    import evad_pkg::*;

    logic [FLEN_W-1:0]   frame_length_reg;
    logic [NEED_W-1:0]   silence_needed_reg;
    logic [THR_W-1:0]    speech_thr_reg;
    logic [THR_W-1:0]    silence_thr_reg;
    logic [MILLIS_W-1:0] frame_millis_reg;

    logic [31:0]         flen_wide;
    logic [LEN_W-1:0]    eff_len_next;
    logic [LEN_W-1:0]    eff_len_reg;
    logic [LVL_W-1:0]    start_level_reg;
    logic [LVL_W-1:0]    quiet_level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_length_reg   <= RST_FRAME_LENGTH;
            silence_needed_reg <= RST_SILENCE_NEEDED;
            speech_thr_reg     <= RST_SPEECH_THR;
            silence_thr_reg    <= RST_SILENCE_THR;
            frame_millis_reg   <= RST_FRAME_MILLIS;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FRAME_LENGTH:   frame_length_reg   <= cfg_data[FLEN_W-1:0];
                REG_SILENCE_NEEDED: silence_needed_reg <= cfg_data[NEED_W-1:0];
                REG_SPEECH_THR:     speech_thr_reg     <= cfg_data[THR_W-1:0];
                REG_SILENCE_THR:    silence_thr_reg    <= cfg_data[THR_W-1:0];
                REG_FRAME_MILLIS:   frame_millis_reg   <= cfg_data[MILLIS_W-1:0];
                default: ;
            endcase
        end
    end

    // Zero length acts as one, anything above the maximum saturates
    always_comb begin
        flen_wide = 32'(frame_length_reg);
        if (flen_wide == 32'd0) begin
            eff_len_next = LEN_W'(1);
        end else if (flen_wide > 32'(FRAME_MAX)) begin
            eff_len_next = LEN_W'(FRAME_MAX);
        end else begin
            eff_len_next = flen_wide[LEN_W-1:0];
        end
    end

    // Levels depend on configuration only; refresh them every cycle
    always_ff @(posedge aclk) begin
        eff_len_reg     <= eff_len_next;
        start_level_reg <= LVL_W'(speech_thr_reg) * LVL_W'(eff_len_next);
        quiet_level_reg <= LVL_W'(silence_thr_reg) * LVL_W'(eff_len_next);
    end

    assign eff_len        = eff_len_reg;
    assign start_level    = start_level_reg;
    assign quiet_level    = quiet_level_reg;
    assign silence_needed = silence_needed_reg;
    assign frame_millis   = frame_millis_reg;

endmodule

[sv/energy_voice_activity_detector_unit.sv]
// ----------------------------------------------------------------------------
// energy_voice_activity_detector_unit
// Frame energy voice activity detector with a silence hangover count.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Beat contents (lowest bit first)
//  -------  ---------  -----------------------------------------------------
//  s_       in         tdata: sample[15:0], zero pad; tuser: restart
//  m_       out        tdata: start flag, end flag, in_speech,
//                      segment_number[31:0], audio_time[47:0], zero pad
//  cfg_     in         write enable, register index, write data
//
//  One sample per cycle sustained while no frame report is stalled. A sample is
//  held in the input register at its beat, squared into the square register
//  and then folded into the detector state.
//  The state update and the result register load on the same edge, so a
//  frame report is valid once the sample that closes the frame is folded in;
//  reports leave in sample order, back to back when frames are one sample.
//  Reset (aresetn low, synchronous) empties the pipe and restores the
//  register defaults and zeroed detector state.
//  A stalled result blocks only a frame-closing sample in the square
//  register; other samples keep accumulating, and s_tready drops once the
//  input register is full behind a blocked square register.
//
module energy_voice_activity_detector_unit #(
    parameter int unsigned FRAME_MAX = evad_pkg::FRAME_MAX_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [evad_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [evad_pkg::CFG_DATA_W-1:0]   cfg_data,
    // sample stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [evad_pkg::S_TDATA_W-1:0]    s_tdata,   // sample[15:0]
    input  logic                              s_tuser,   // restart
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // start flag, end flag, in_speech, segment_number, audio_time
    output logic [evad_pkg::M_TDATA_W-1:0]    m_tdata
);
    import evad_pkg::*;

    localparam int unsigned LEN_W = $clog2(FRAME_MAX + 1);
    localparam int unsigned LVL_W = THR_W + LEN_W;
    localparam int unsigned CMP_W = (LVL_W > SUM_W) ? LVL_W : SUM_W;

    // ---------------- configuration ----------------
    logic [LEN_W-1:0]    eff_len;
    logic [LVL_W-1:0]    start_level;
    logic [LVL_W-1:0]    quiet_level;
    logic [NEED_W-1:0]   silence_needed;
    logic [MILLIS_W-1:0] frame_millis;

    evad_cfg_regs #(
        .FRAME_MAX (FRAME_MAX),
        .LEN_W     (LEN_W),
        .LVL_W     (LVL_W)
    ) u_cfg (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .eff_len        (eff_len),
        .start_level    (start_level),
        .quiet_level    (quiet_level),
        .silence_needed (silence_needed),
        .frame_millis   (frame_millis)
    );

    // ---------------- pipeline control ----------------
    logic s1_valid_reg, s2_valid_reg;
    logic out_free;      // result register can take a new result
    logic frame_end;     // sample in stage 2 closes the frame
    logic s3_go;         // stage 2 sample updates the state this edge
    logic s2_load;
    logic s1_load;

    assign out_free = !m_tvalid || m_tready;
    assign s3_go    = s2_valid_reg && (!frame_end || out_free);
    assign s2_load  = s1_valid_reg && (!s2_valid_reg || s3_go);
    assign s_tready = !s1_valid_reg || s2_load;
    assign s1_load  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            // hold a stage while its successor is blocked
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (!s2_valid_reg || s3_go) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // ---------------- stage 1: input register ----------------
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic                s1_restart_reg;

    always_ff @(posedge aclk) begin
        if (s1_load) begin
            s1_sample_reg  <= s_tdata[SAMPLE_W-1:0];
            s1_restart_reg <= s_tuser;
        end
    end

    // ---------------- stage 2: square ----------------
    logic [SAMPLE_W-1:0] s1_mag;
    logic [31:0]         s1_prod;
    logic [SQ_W-1:0]     s2_sq_reg;
    logic                s2_restart_reg;

    // magnitude of the most negative sample is 2^15, still fits unsigned
    assign s1_mag  = s1_sample_reg[SAMPLE_W-1] ? (~s1_sample_reg + 1'b1) : s1_sample_reg;
    assign s1_prod = 32'(s1_mag) * 32'(s1_mag);

    always_ff @(posedge aclk) begin
        if (s2_load) begin
            s2_sq_reg      <= s1_prod[SQ_W-1:0];
            s2_restart_reg <= s1_restart_reg;
        end
    end

    // ---------------- stage 3: accumulate and decide ----------------
    logic [SUM_W-1:0]   energy_sum_reg,  energy_sum_next;
    logic [LEN_W-1:0]   frame_fill_reg,  frame_fill_next;
    logic               speech_reg,      speech_next;
    logic [QUIET_W-1:0] quiet_reg,       quiet_next;
    logic [SEG_W-1:0]   segments_reg,    segments_next;
    logic [TIME_W-1:0]  elapsed_reg,     elapsed_next;

    logic               speech_base;
    logic [QUIET_W-1:0] quiet_base;
    logic [QUIET_W-1:0] quiet_inc;
    logic [SUM_W-1:0]   sum_add;
    logic [LEN_W-1:0]   fill_inc;
    logic [CMP_W-1:0]   sum_cmp;
    logic               started, ended;

    assign sum_add   = energy_sum_reg + SUM_W'(s2_sq_reg);
    assign fill_inc  = frame_fill_reg + 1'b1;
    assign frame_end = (fill_inc >= eff_len);
    assign sum_cmp   = CMP_W'(sum_add);

    always_comb begin
        // restart drops speech and the quiet count before the sample counts
        speech_base = s2_restart_reg ? 1'b0 : speech_reg;
        quiet_base  = s2_restart_reg ? '0 : quiet_reg;
        quiet_inc   = quiet_base + 1'b1;

        started         = 1'b0;
        ended           = 1'b0;
        energy_sum_next = sum_add;
        frame_fill_next = fill_inc;
        speech_next     = speech_base;
        quiet_next      = quiet_base;
        segments_next   = segments_reg;
        elapsed_next    = elapsed_reg;

        if (frame_end) begin
            if (!speech_base) begin
                if (sum_cmp >= CMP_W'(start_level)) begin
                    speech_next = 1'b1;
                    quiet_next  = '0;
                    started     = 1'b1;
                end
            end else if (sum_cmp <= CMP_W'(quiet_level)) begin
                quiet_next = quiet_inc;
                // zero needed behaves as one: first quiet frame ends speech
                if (quiet_inc >= silence_needed) begin
                    speech_next = 1'b0;
                    quiet_next  = '0;
                    ended       = 1'b1;
                end
            end else begin
                quiet_next = '0;
            end
            elapsed_next    = elapsed_reg + TIME_W'(frame_millis);
            segments_next   = segments_reg + SEG_W'(ended);
            energy_sum_next = '0;
            frame_fill_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            energy_sum_reg <= '0;
            frame_fill_reg <= '0;
            speech_reg     <= 1'b0;
            quiet_reg      <= '0;
            segments_reg   <= '0;
            elapsed_reg    <= '0;
        end else if (s3_go) begin
            energy_sum_reg <= energy_sum_next;
            frame_fill_reg <= frame_fill_next;
            speech_reg     <= speech_next;
            quiet_reg      <= quiet_next;
            segments_reg   <= segments_next;
            elapsed_reg    <= elapsed_next;
        end
    end

    // ---------------- result register ----------------
    logic                 m_valid_reg;
    logic [M_USED_W-1:0]  m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s3_go && frame_end) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_go && frame_end) begin
            m_data_reg <= {elapsed_next, segments_next, speech_next, ended, started};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_data_reg);

endmodule

[sv/evad_port_checker.sv]
// ----------------------------------------------------------------------------
// evad_port_checker
// Port-level checks of the detector's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module evad_port_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [evad_pkg::M_TDATA_W-1:0]   m_tdata
);
    import evad_pkg::*;

    logic              started, ended, in_speech;
    logic [SEG_W-1:0]  seg;
    logic [SEG_W-1:0]  last_seg_reg;

    assign started   = m_tdata[M_STARTED_BIT];
    assign ended     = m_tdata[M_ENDED_BIT];
    assign in_speech = m_tdata[M_INSPEECH_BIT];
    assign seg       = m_tdata[M_SEG_LSB +: SEG_W];

    // track the segment count of the last delivered result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_seg_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            last_seg_reg <= seg;
        end
    end

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled result keeps its beat
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // start and end flags agree with the speech flag
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(started && ended) && (!started || in_speech)
                     && (!ended || !in_speech))
        else $error("inconsistent speech flags");

    // the segment count moves only with a closed segment
    a_segments: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |-> seg == last_seg_reg + SEG_W'(ended))
        else $error("segment count out of step");

endmodule

bind energy_voice_activity_detector_unit evad_port_checker u_evad_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
